// File: src/byte_automaton_matcher_top_assert.svh
// Assertion macros for the byte automaton matcher checker.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef BYTE_AUTOMATON_MATCHER_TOP_ASSERT_SVH
`define BYTE_AUTOMATON_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BAM_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("bam checker: same-cycle property failed");

// Next-cycle implication, disabled during reset.
`define BAM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("bam checker: next-cycle property failed");

`endif

// File: src/bam_pkg.sv
// Shared types and constants for the byte automaton matcher.
// No dependencies; every file but bam_ram and the assertion header imports this package.
package bam_pkg;

  localparam int NODE_W         = 6;
  localparam int SYM_W          = 8;
  localparam int OP_W           = 3;
  localparam int STATUS_W       = 2;
  localparam int MAX_NODES      = 64;
  localparam int LINKS_PER_NODE = 8;
  localparam int NODE_CNT_W     = NODE_W + 1;
  localparam int LINK_CNT_W     = $clog2(LINKS_PER_NODE + 1);
  localparam int LINK_W         = SYM_W + NODE_W;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_LINK   = 3'd1;
  localparam logic [OP_W-1:0] OP_START  = 3'd2;
  localparam logic [OP_W-1:0] OP_SYMBOL = 3'd3;
  localparam logic [OP_W-1:0] OP_END    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NODES_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LINKS_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [NODE_W-1:0] from_node;
    logic              final_flag;
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] next_node;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NODE_W-1:0]   node_id;
    logic                alive;
    logic                matched;
  } result_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_CREATE,
    K_LINK,
    K_START,
    K_SYMBOL,
    K_END
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [NODE_W-1:0] from_node;
    logic              final_flag;
    logic [SYM_W-1:0]  symbol;
    logic [NODE_W-1:0] next_node;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } back_state_t;

endpackage

// File: src/bam_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/bam_front.sv
// Front end: decodes incoming items into commands and buffers them in a short queue.
// Depends on bam_pkg.
module bam_front (
  input  logic          clk,
  input  logic          rst,
  input  bam_pkg::item_t item,
  input  logic          item_valid,
  output logic          item_ready,
  output bam_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import bam_pkg::*;

  cmd_t              slot [QUEUE_DEPTH];
  cmd_t              decoded;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  always_comb begin
    decoded.from_node  = item.from_node;
    decoded.final_flag = item.final_flag;
    decoded.symbol     = item.symbol;
    decoded.next_node  = item.next_node;
    case (item.opcode)
      OP_CREATE: decoded.kind = K_CREATE;
      OP_LINK:   decoded.kind = K_LINK;
      OP_START:  decoded.kind = K_START;
      OP_SYMBOL: decoded.kind = K_SYMBOL;
      OP_END:    decoded.kind = K_END;
      default:   decoded.kind = K_NONE;
    endcase
  end

  assign item_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid  = (fill != '0);
  assign cmd        = slot[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: src/bam_back.sv
// Back end: runs one command at a time against the node and link stores.
// Depends on bam_pkg and bam_ram.
module bam_back (
  input  logic            clk,
  input  logic            rst,
  input  bam_pkg::cmd_t   cmd,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  output logic            result_valid,
  input  logic            result_ready,
  output bam_pkg::result_t result
);
  import bam_pkg::*;

  back_state_t            state;
  cmd_t                   op_q;
  logic [NODE_CNT_W-1:0]  node_count;
  logic [NODE_CNT_W-1:0]  node_count_next;
  logic [NODE_W-1:0]      current_node;
  logic [NODE_W-1:0]      current_node_next;
  logic                   walk_alive;
  logic                   walk_alive_next;
  result_t                res;

  logic                   rd_en;
  logic [NODE_W-1:0]      rd_addr;
  logic                   commit;
  logic                   from_ok;
  logic                   next_ok;
  logic                   created;
  logic                   found;
  logic [NODE_W-1:0]      target;

  logic                   acc_we;
  logic [0:0]             acc_wdata;
  logic [0:0]             acc_rd;
  logic                   cnt_we;
  logic [NODE_W-1:0]      cnt_waddr;
  logic [LINK_CNT_W-1:0]  cnt_wdata;
  logic [LINK_CNT_W-1:0]  cnt_rd;
  logic [LINKS_PER_NODE-1:0] lane_we;
  logic [LINK_W-1:0]      lane_rd [LINKS_PER_NODE];

  assign cmd_ready = (state == S_IDLE);
  assign rd_en     = (state == S_IDLE) && cmd_valid;
  assign rd_addr   = (cmd.kind == K_LINK || cmd.kind == K_START) ? cmd.from_node
                                                                  : current_node;
  assign commit    = (state == S_EXEC) && (!result_valid || result_ready);
  assign acc_wdata = op_q.final_flag;

  bam_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_accept (
    .clk   (clk),
    .we    (acc_we),
    .waddr (node_count[NODE_W-1:0]),
    .wdata (acc_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (acc_rd)
  );

  bam_ram #(.WIDTH(LINK_CNT_W), .DEPTH(MAX_NODES)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (cnt_rd)
  );

  // One RAM per link slot so a whole row is read at once.
  for (genvar g = 0; g < LINKS_PER_NODE; g++) begin : g_lane
    bam_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_lane (
      .clk   (clk),
      .we    (lane_we[g]),
      .waddr (op_q.from_node),
      .wdata ({op_q.symbol, op_q.next_node}),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (lane_rd[g])
    );
  end

  always_comb begin
    from_ok           = {1'b0, op_q.from_node} < node_count;
    next_ok           = {1'b0, op_q.next_node} < node_count;
    res.status        = ST_OK;
    res.matched       = 1'b0;
    node_count_next   = node_count;
    current_node_next = current_node;
    walk_alive_next   = walk_alive;
    acc_we            = 1'b0;
    cnt_we            = 1'b0;
    cnt_waddr         = op_q.from_node;
    cnt_wdata         = cnt_rd + 1'b1;
    lane_we           = '0;
    created           = 1'b0;
    found             = 1'b0;
    target            = current_node;

    // Scan from the top so the earliest matching link wins.
    for (int i = LINKS_PER_NODE - 1; i >= 0; i--) begin
      if (LINK_CNT_W'(i) < cnt_rd && lane_rd[i][LINK_W-1:NODE_W] == op_q.symbol) begin
        found  = 1'b1;
        target = lane_rd[i][NODE_W-1:0];
      end
    end

    case (op_q.kind)
      K_CREATE: begin
        if (node_count >= NODE_CNT_W'(MAX_NODES)) begin
          res.status = ST_NODES_FULL;
        end else begin
          acc_we          = commit;
          cnt_we          = commit;
          cnt_waddr       = node_count[NODE_W-1:0];
          cnt_wdata       = '0;
          node_count_next = node_count + 1'b1;
          created         = 1'b1;
        end
      end
      K_LINK: begin
        if (!from_ok || !next_ok) begin
          res.status = ST_BAD_INDEX;
        end else if (cnt_rd >= LINK_CNT_W'(LINKS_PER_NODE)) begin
          res.status = ST_LINKS_FULL;
        end else begin
          cnt_we = commit;
          for (int i = 0; i < LINKS_PER_NODE; i++) begin
            lane_we[i] = commit && (cnt_rd == LINK_CNT_W'(i));
          end
        end
      end
      K_START: begin
        if (!from_ok) begin
          res.status      = ST_BAD_INDEX;
          walk_alive_next = 1'b0;
        end else begin
          current_node_next = op_q.from_node;
          walk_alive_next   = 1'b1;
        end
      end
      K_SYMBOL: begin
        if (walk_alive && found) begin
          current_node_next = target;
        end else begin
          walk_alive_next = 1'b0;
        end
      end
      K_END: begin
        res.matched = walk_alive && acc_rd[0];
      end
      default: begin
      end
    endcase

    res.node_id = created ? node_count[NODE_W-1:0] : current_node_next;
    res.alive   = walk_alive_next;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      op_q <= cmd;
    end
    if (commit) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      node_count   <= '0;
      current_node <= '0;
      walk_alive   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // Hold here while the output register is still occupied.
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (commit) begin
        node_count   <= node_count_next;
        current_node <= current_node_next;
        walk_alive   <= walk_alive_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/byte_automaton_matcher_top.sv
// Byte automaton matcher: builds a byte-labelled automaton in a node table and
// walks it one input byte at a time.
//
// Input channel item_valid/item_ready/item carries one command per item: create
// node, add link, start walk, symbol, end of string. Output channel
// result_valid/result_ready/result returns exactly one result per item, in order.
// An accepted item passes through the queue, then the back end's command register
// and registered read of the node's link row, then the compare and update into
// the result register; a new command is taken only after the last one commits.
// A two-entry queue sits between the decoding front end and the back end, so the
// input keeps taking items while a result waits to be taken.
// When result_ready is low the back end holds its finished command, then the
// queue fills and item_ready drops; nothing is lost or repeated.
// Reset (rst, synchronous, active high) empties the queue and output, clears the
// node count, current node and walk state. Node and link stores are not cleared;
// entries are read before being written only where the result ignores them.
// Depends on bam_pkg, bam_front, bam_back, bam_ram.
module byte_automaton_matcher_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  bam_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output bam_pkg::result_t result
);
  import bam_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  bam_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready)
  );

  bam_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// File: src/bam_checker.sv
// Port-level checker for the byte automaton matcher, bound to the top level.
// Depends on bam_pkg and byte_automaton_matcher_top_assert.svh.
`include "byte_automaton_matcher_top_assert.svh"

module bam_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input bam_pkg::result_t result
);
  import bam_pkg::*;

  logic [2:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = item_valid && item_ready;
  assign out_acc = result_valid && result_ready;

  // Track items taken in but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 1'b1;
    end
  end

  `BAM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))
  `BAM_ASSERT_NOW(a_reset_empty, $fell(rst), item_ready && !result_valid)
  `BAM_ASSERT_NOW(a_no_invented, result_valid, pending != 3'd0)
  `BAM_ASSERT_NOW(a_in_flight_bound, in_acc, pending < 3'd4)
  `BAM_ASSERT_NOW(a_match_alive, result_valid && result.matched, result.alive && result.status == ST_OK)

endmodule

bind byte_automaton_matcher_top bam_checker u_checker (.*);

// File: dv/tb_top.sv
// Testbench for byte_automaton_matcher_top: builds automata, walks them and checks
// every result against a cycle-free model of the node table, in item order.
// Depends on bam_pkg and the matcher RTL.
`timescale 1ns / 100ps

module tb_top;
  import bam_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  // Tracks the automaton as the block should see it and holds the results owed.
  class automaton_tracker;
    int unsigned      node_count;
    bit               accepting[MAX_NODES];
    int unsigned      link_count[MAX_NODES];
    bit [SYM_W-1:0]   link_sym[MAX_NODES][LINKS_PER_NODE];
    bit [NODE_W-1:0]  link_dst[MAX_NODES][LINKS_PER_NODE];
    bit [NODE_W-1:0]  cur_node;
    bit               alive;
    result_t          owed_results[$];
    int unsigned      errors;

    function new();
      node_count = 0;
      cur_node   = '0;
      alive      = 1'b0;
      errors     = 0;
    endfunction

    function bit node_known(int unsigned n);
      return n < node_count;
    endfunction

    function void note_item(item_t it);
      result_t r;
      bit      created;
      bit      found;
      int unsigned slot;
      r       = '0;
      created = 1'b0;
      case (it.opcode)
        OP_CREATE: begin
          if (node_count >= MAX_NODES) begin
            r.status = ST_NODES_FULL;
          end else begin
            r.node_id              = NODE_W'(node_count);
            accepting[node_count]  = it.final_flag;
            link_count[node_count] = 0;
            node_count++;
            created = 1'b1;
          end
        end
        OP_LINK: begin
          if (!node_known(it.from_node) || !node_known(it.next_node)) begin
            r.status = ST_BAD_INDEX;
          end else if (link_count[it.from_node] >= LINKS_PER_NODE) begin
            r.status = ST_LINKS_FULL;
          end else begin
            slot = link_count[it.from_node];
            link_sym[it.from_node][slot] = it.symbol;
            link_dst[it.from_node][slot] = it.next_node;
            link_count[it.from_node]++;
          end
        end
        OP_START: begin
          if (!node_known(it.from_node)) begin
            r.status = ST_BAD_INDEX;
            alive    = 1'b0;
          end else begin
            cur_node = it.from_node;
            alive    = 1'b1;
          end
        end
        OP_SYMBOL: begin
          found = 1'b0;
          if (alive && node_known(cur_node)) begin
            // first matching link in insertion order wins
            for (int i = 0; i < link_count[cur_node]; i++) begin
              if (!found && link_sym[cur_node][i] == it.symbol) begin
                cur_node = link_dst[cur_node][i];
                found    = 1'b1;
              end
            end
          end
          if (!found) alive = 1'b0;
        end
        OP_END: begin
          r.matched = alive && node_known(cur_node) && accepting[cur_node];
        end
        default: begin
        end
      endcase
      if (!created) r.node_id = cur_node;
      r.alive = alive;
      owed_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $error("result with no item pending: %p", got);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.node_id !== want.node_id) begin
        $error("node_id: expected %0d, got %0d", want.node_id, got.node_id);
        errors++;
      end
      if (got.alive !== want.alive) begin
        $error("alive: expected %0d, got %0d", want.alive, got.alive);
        errors++;
      end
      if (got.matched !== want.matched) begin
        $error("matched: expected %0d, got %0d", want.matched, got.matched);
        errors++;
      end
    endfunction
  endclass

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  automaton_tracker tracker = new();
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned idle_cycles = 0;

  byte_automaton_matcher_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #10 clk = ~clk;

  function automatic item_t make_item(logic [OP_W-1:0] op, int from, bit fin, int sym,
                                      int nxt);
    item_t it;
    it.opcode     = op;
    it.from_node  = NODE_W'(from);
    it.final_flag = fin;
    it.symbol     = SYM_W'(sym);
    it.next_node  = NODE_W'(nxt);
    return it;
  endfunction

  function automatic item_t rand_item();
    return make_item(OP_W'($urandom_range(0, 7)), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)), $urandom_range(0, 255),
                     $urandom_range(0, 63));
  endfunction

  // mostly an existing node, now and then any index
  function automatic int pick_node();
    if (tracker.node_count == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, tracker.node_count - 1);
  endfunction

  // small alphabet so labels collide and walks find links
  function automatic int pick_label();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, 7);
  endfunction

  function automatic int walk_symbol();
    int unsigned cnt;
    cnt = tracker.link_count[tracker.cur_node];
    if (tracker.alive && cnt > 0 && $urandom_range(0, 4) != 0)
      return tracker.link_sym[tracker.cur_node][$urandom_range(0, cnt - 1)];
    return pick_label();
  endfunction

  // Call at a rising edge; returns at the edge that accepts the item.
  task automatic send_item(item_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    tracker.note_item(it);
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
  endtask

  // Receiver: random stalls, check each accepted result.
  initial begin
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      tracker.check_result(result);
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    item_t it;
    int    len;
    int    sent;
    int    pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty table first: items on nodes that do not exist yet, then creates and links
    send_item(make_item(OP_END, 0, 1, 0, 0));
    send_item(make_item(OP_SYMBOL, 0, 0, 0, 0));
    send_item(make_item(OP_START, 0, 0, 0, 0));
    send_item(make_item(OP_LINK, 0, 0, 0, 0));
    send_item(make_item(OP_SPARE_LO, 63, 1, 255, 63));
    send_item(make_item(OP_SPARE_HI, 0, 0, 0, 0));
    send_item(make_item(OP_CREATE, 0, 0, 0, 0));
    send_item(make_item(OP_CREATE, 63, 1, 255, 63));
    send_item(make_item(OP_CREATE, 0, 0, 0, 0));
    send_item(make_item(OP_LINK, 0, 0, 0, 1));
    send_item(make_item(OP_LINK, 0, 1, 255, 2));
    send_item(make_item(OP_LINK, 0, 0, 0, 2));
    send_item(make_item(OP_LINK, 1, 0, 8'hA5, 1));
    send_item(make_item(OP_LINK, 0, 0, 1, 63));
    // fill node 1, then one link too many
    for (int i = 0; i < LINKS_PER_NODE; i++)
      send_item(make_item(OP_LINK, 1, 0, i, 2));
    send_item(make_item(OP_START, 0, 0, 0, 0));
    send_item(make_item(OP_SYMBOL, 0, 0, 0, 0));
    send_item(make_item(OP_SYMBOL, 0, 0, 8'hA5, 0));
    send_item(make_item(OP_END, 0, 0, 0, 0));
    send_item(make_item(OP_SYMBOL, 0, 0, 8'hEE, 0));
    send_item(make_item(OP_END, 0, 0, 0, 0));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        it = rand_item();
        it.opcode = OP_CREATE;
        send_item(it);
        sent++;
      end else if (pick < 40) begin
        it = rand_item();
        it.opcode    = OP_LINK;
        it.from_node = NODE_W'(pick_node());
        it.next_node = NODE_W'(pick_node());
        it.symbol    = SYM_W'(pick_label());
        send_item(it);
        sent++;
      end else if (pick < 88) begin
        // start, up to six bytes, then mostly an end
        it = rand_item();
        it.opcode    = OP_START;
        it.from_node = NODE_W'(pick_node());
        send_item(it);
        sent++;
        len = $urandom_range(0, 6);
        repeat (len) begin
          it = rand_item();
          it.opcode = OP_SYMBOL;
          it.symbol = SYM_W'(walk_symbol());
          send_item(it);
          sent++;
        end
        if ($urandom_range(0, 9) != 0) begin
          it = rand_item();
          it.opcode = OP_END;
          send_item(it);
          sent++;
        end
      end else begin
        send_item(rand_item());
        sent++;
      end
    end
    item_valid <= 1'b0;

    while (tracker.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/bam_pkg.sv
src/bam_ram.sv
src/bam_front.sv
src/bam_back.sv
src/byte_automaton_matcher_top.sv
src/bam_checker.sv
dv/tb_top.sv
